FILE: sv/rvcx_pkg.sv
// ----------------------------------------------------------------------------
// RVC expander package
// Shared codes, the decoded-instruction record and the RV32I field packer.
// ----------------------------------------------------------------------------
package rvcx_pkg;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned WORD_W = 32;

  // Base opcodes used by the expansions.
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [WORD_W-1:0] WORD_EBREAK = 32'h0010_0073;

  // Instruction formats chosen by the decoder.
  localparam logic [2:0] FMT_I   = 3'd0;
  localparam logic [2:0] FMT_S   = 3'd1;
  localparam logic [2:0] FMT_B   = 3'd2;
  localparam logic [2:0] FMT_J   = 3'd3;
  localparam logic [2:0] FMT_U   = 3'd4;
  localparam logic [2:0] FMT_R   = 3'd5;
  localparam logic [2:0] FMT_SYS = 3'd6;

  typedef struct packed {
    logic              illegal;
    logic [2:0]        fmt;
    logic [6:0]        opcode;
    logic [6:0]        funct7;
    logic [2:0]        funct3;
    logic [4:0]        rd;
    logic [4:0]        rs1;
    logic [4:0]        rs2;
    logic [WORD_W-1:0] imm;   // sign-extended value; U format holds it pre-shifted
  } dec_t;

  // Packs a decoded record into the 32-bit encoding; zero when illegal.
  function automatic logic [WORD_W-1:0] encode(input dec_t d);
    logic [WORD_W-1:0] w;
    w = '0;
    case (d.fmt)
      FMT_I:   w = {d.imm[11:0], d.rs1, d.funct3, d.rd, d.opcode};
      FMT_S:   w = {d.imm[11:5], d.rs2, d.rs1, d.funct3, d.imm[4:0], d.opcode};
      FMT_B:   w = {d.imm[12], d.imm[10:5], d.rs2, d.rs1, d.funct3,
                    d.imm[4:1], d.imm[11], d.opcode};
      FMT_J:   w = {d.imm[20], d.imm[10:1], d.imm[11], d.imm[19:12], d.rd, d.opcode};
      FMT_U:   w = {d.imm[31:12], d.rd, d.opcode};
      FMT_R:   w = {d.funct7, d.rs2, d.rs1, d.funct3, d.rd, d.opcode};
      FMT_SYS: w = WORD_EBREAK;
      default: w = '0;
    endcase
    if (d.illegal) begin
      w = '0;
    end
    return w;
  endfunction

endpackage

FILE: sv/rvc_instruction_expander.sv
// ----------------------------------------------------------------------------
// RVC instruction expander
// Expands each 16-bit compressed parcel into its 32-bit RV32I encoding.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Payload
// s_*      in         tdata[15:0] = half_word
// m_*      out        tdata[31:0] = expanded_word, tuser[0] = illegal
//
// Every parcel passes from its transfer in to its result being shown on
// m_tvalid through an input register, a register after decode, and the
// output register after the word is packed. A new parcel may be taken every
// cycle. Each stage holds its own valid bit and advances whenever the stage
// after it is empty or moving, so a stall on m_tready fills the empty
// stages first and loses nothing. Reset clears the valid bits only.
//
module rvc_instruction_expander
  import rvcx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [HALF_W-1:0] s_tdata,   // [15:0] half_word
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,   // [31:0] expanded_word
  output logic              m_tuser    // [0] illegal
);

  logic              s1_valid;
  logic [HALF_W-1:0] s1_half;
  logic              s2_valid;
  dec_t              s2_dec;
  dec_t              dec_next;

  logic out_load;
  logic s2_load;
  logic s1_load;

  // A stage may load when it is empty or its contents move on this cycle.
  assign out_load = !m_tvalid || m_tready;
  assign s2_load  = !s2_valid || out_load;
  assign s1_load  = !s1_valid || s2_load;
  assign s_tready = s1_load;

  // Stage one: capture the parcel.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= s_tvalid;
    end
    if (s1_load && s_tvalid) begin
      s1_half <= s_tdata;
    end
  end

  rvcx_decode u_decode (
    .half_word (s1_half),
    .dec       (dec_next)
  );

  // Stage two: hold the decoded record.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
    if (s2_load && s1_valid) begin
      s2_dec <= dec_next;
    end
  end

  // Stage three: pack the fields into the final word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s2_valid;
    end
    if (out_load && s2_valid) begin
      m_tdata <= encode(s2_dec);
      m_tuser <= s2_dec.illegal;
    end
  end

endmodule

FILE: sv/rvcx_decode.sv
// ----------------------------------------------------------------------------
// RVC parcel decoder
// Sorts a 16-bit parcel into format, registers and immediate, with legality.
// ----------------------------------------------------------------------------
module rvcx_decode
  import rvcx_pkg::*;
(
  input  logic [HALF_W-1:0] half_word,
  output dec_t              dec
);

  // Key of the register-register arithmetic group: funct6 and funct2.
  localparam logic [7:0] KEY_AND = 8'h8F;
  localparam logic [7:0] KEY_OR  = 8'h8E;
  localparam logic [7:0] KEY_XOR = 8'h8D;
  localparam logic [7:0] KEY_SUB = 8'h8C;

  logic [HALF_W-1:0] h;
  logic [2:0]        f3;
  logic [4:0]        rd;
  logic [4:0]        rs2;
  logic [4:0]        rdp;
  logic [4:0]        rs1p;
  logic [5:0]        raw6;
  logic [WORD_W-1:0] imm6;
  logic [11:0]       jimm;
  logic [8:0]        bimm;
  logic [9:0]        imm10;
  logic [7:0]        key;

  assign h    = half_word;
  assign f3   = h[15:13];
  assign rd   = h[11:7];
  assign rs2  = h[6:2];
  assign rdp  = {2'b01, h[4:2]};
  assign rs1p = {2'b01, h[9:7]};
  assign raw6 = {h[12], h[6:2]};
  assign imm6 = {{26{h[12]}}, raw6};
  assign jimm = {h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
  assign bimm = {h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
  assign imm10 = {h[12], h[4:3], h[5], h[2], h[6], 4'b0000};
  assign key  = {h[15:10], h[6:5]};

  always_comb begin
    dec         = '0;
    dec.fmt     = FMT_I;
    dec.opcode  = OPC_OPIMM;
    unique case (h[1:0])
      2'd0: begin
        dec.rd  = rdp;
        dec.rs1 = rs1p;
        case (f3)
          3'd0: begin
            dec.imm = {22'd0, h[10:7], h[12:11], h[5], h[6], 2'b00};
            dec.rs1 = 5'd2;
            dec.illegal = (h[12:5] == 8'd0);
          end
          3'd2: begin
            dec.imm    = {25'd0, h[5], h[12:10], h[6], 2'b00};
            dec.opcode = OPC_LOAD;
            dec.funct3 = 3'd2;
          end
          3'd6: begin
            dec.imm    = {25'd0, h[5], h[12:10], h[6], 2'b00};
            dec.fmt    = FMT_S;
            dec.opcode = OPC_STORE;
            dec.funct3 = 3'd2;
            dec.rs2    = rdp;
          end
          default: dec.illegal = 1'b1;
        endcase
      end
      2'd1: begin
        case (f3)
          3'd0: begin
            dec.imm = imm6;
            dec.rd  = rd;
            dec.rs1 = rd;
            dec.illegal = (rd != 5'd0) && (raw6 == 6'd0);
          end
          3'd1, 3'd5: begin
            dec.fmt    = FMT_J;
            dec.opcode = OPC_JAL;
            dec.imm    = {{20{jimm[11]}}, jimm};
            dec.rd     = (f3 == 3'd1) ? 5'd1 : 5'd0;
          end
          3'd2: begin
            dec.imm = imm6;
            dec.rd  = rd;
            dec.illegal = (rd == 5'd0);
          end
          3'd3: begin
            if (rd == 5'd2) begin
              dec.imm = {{22{imm10[9]}}, imm10};
              dec.rd  = 5'd2;
              dec.rs1 = 5'd2;
              dec.illegal = (imm10 == 10'd0);
            end else begin
              dec.fmt    = FMT_U;
              dec.opcode = OPC_LUI;
              dec.imm    = {imm6[19:0], 12'd0};
              dec.rd     = rd;
              dec.illegal = (rd == 5'd0) || (raw6 == 6'd0);
            end
          end
          3'd4: begin
            dec.rd  = rs1p;
            dec.rs1 = rs1p;
            case (h[11:10])
              2'd0: begin
                dec.imm    = {27'd0, h[6:2]};
                dec.funct3 = 3'd5;
                dec.illegal = h[12];
              end
              2'd1: begin
                dec.imm    = {20'd0, 7'b0100000, h[6:2]};
                dec.funct3 = 3'd5;
                dec.illegal = h[12];
              end
              2'd2: begin
                dec.imm    = imm6;
                dec.funct3 = 3'd7;
              end
              default: begin
                dec.fmt    = FMT_R;
                dec.opcode = OPC_OP;
                dec.rs2    = rdp;
                case (key)
                  KEY_AND: dec.funct3 = 3'd7;
                  KEY_OR:  dec.funct3 = 3'd6;
                  KEY_XOR: dec.funct3 = 3'd4;
                  KEY_SUB: dec.funct7 = 7'h20;
                  default: dec.illegal = 1'b1;
                endcase
              end
            endcase
          end
          default: begin
            dec.fmt    = FMT_B;
            dec.opcode = OPC_BRANCH;
            dec.imm    = {{23{bimm[8]}}, bimm};
            dec.rs1    = rs1p;
            dec.funct3 = {2'b00, f3[0]};
          end
        endcase
      end
      2'd2: begin
        dec.rd = rd;
        case (f3)
          3'd0: begin
            dec.imm    = {27'd0, rs2};
            dec.rs1    = rd;
            dec.funct3 = 3'd1;
            dec.illegal = (rd == 5'd0) || h[12];
          end
          3'd2: begin
            dec.imm    = {24'd0, h[3:2], h[12], h[6:4], 2'b00};
            dec.opcode = OPC_LOAD;
            dec.rs1    = 5'd2;
            dec.funct3 = 3'd2;
            dec.illegal = (rd == 5'd0);
          end
          3'd6: begin
            dec.imm    = {24'd0, h[8:7], h[12:9], 2'b00};
            dec.fmt    = FMT_S;
            dec.opcode = OPC_STORE;
            dec.rs1    = 5'd2;
            dec.rs2    = rs2;
            dec.funct3 = 3'd2;
          end
          3'd4: begin
            if (!h[12]) begin
              dec.illegal = (rd == 5'd0);
              if (rs2 != 5'd0) begin
                dec.fmt    = FMT_R;
                dec.opcode = OPC_OP;
                dec.rs2    = rs2;
              end else begin
                dec.opcode = OPC_JALR;
                dec.rs1    = rd;
                dec.rd     = 5'd0;
              end
            end else if (rs2 == 5'd0) begin
              if (rd == 5'd0) begin
                dec.fmt = FMT_SYS;
              end else begin
                dec.opcode = OPC_JALR;
                dec.rs1    = rd;
                dec.rd     = 5'd1;
              end
            end else begin
              dec.fmt    = FMT_R;
              dec.opcode = OPC_OP;
              dec.rs1    = rd;
              dec.rs2    = rs2;
            end
          end
          default: dec.illegal = 1'b1;
        endcase
      end
      default: dec.illegal = 1'b1;
    endcase
  end

endmodule
